FILE: design/lcd_controller_index_data_port_defines.svh
// Assertion macros for the LCD controller index/data port
`ifndef LCD_CONTROLLER_INDEX_DATA_PORT_DEFINES_SVH
`define LCD_CONTROLLER_INDEX_DATA_PORT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define LCDC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define LCDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LCDC_ASSERT_IMPL(label, ante, cons, msg)

`define LCDC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: design/lcdc_pkg.sv
// Package: constants, types and helpers of the LCD controller index/data port
`default_nettype none
package lcdc_pkg;

	localparam int PANEL_WIDTH  = 160;
	localparam int PANEL_HEIGHT = 100;
	localparam int STRIDE       = (PANEL_WIDTH + 3) / 4;
	localparam int MEM_SIZE     = STRIDE * PANEL_HEIGHT;
	localparam int MEM_AW       = $clog2(MEM_SIZE);

	localparam int IDX_W = 5;
	localparam logic [IDX_W-1:0] DATA_REG_NUM  = IDX_W'(4);
	localparam logic [IDX_W-1:0] XADDR_REG_NUM = IDX_W'(2);
	localparam logic [IDX_W-1:0] YADDR_REG_NUM = IDX_W'(3);
	localparam logic [IDX_W-1:0] DISP_REG_NUM  = IDX_W'(0);
	localparam int NUM_REGS    = 1 << IDX_W;
	localparam int DISP_ON_BIT = 6;

	localparam logic [1:0] PORT_INDEX = 2'd0;
	localparam logic [1:0] PORT_DATA  = 2'd1;

	typedef struct packed {
		logic              re;
		logic              we;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        wdata;
	} dmem_req_t;

	// (v mod STRIDE) for v up to 511, by restoring subtraction
	function automatic logic [7:0] mod_stride(input logic [8:0] v);
		logic [16:0] r;
		r = 17'(v);
		for (int k = 8; k >= 0; k--) begin
			if (r >= (17'(STRIDE) << k)) begin
				r = r - (17'(STRIDE) << k);
			end
		end
		return r[7:0];
	endfunction

endpackage
`default_nettype wire

FILE: design/lcdc_if.sv
// Valid/ready channel interfaces for request and result transfers
`default_nettype none
interface lcdc_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [1:0] port_sel;
	logic [7:0] write_data;
	logic [7:0] dot_x;
	logic [7:0] dot_y;

	modport source (output valid, op, port_sel, write_data, dot_x, dot_y, input ready);
	modport sink   (input valid, op, port_sel, write_data, dot_x, dot_y, output ready);
endinterface

interface lcdc_rsp_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [1:0] dot_level;
	logic       display_on;

	modport source (output valid, accepted, dot_level, display_on, input ready);
	modport sink   (input valid, accepted, dot_level, display_on, output ready);
endinterface
`default_nettype wire

FILE: design/lcd_controller_index_data_port.sv
// LCD controller index/data port: one bus write or dot query per cycle while
// rsp.ready does not stall, one result each. Each request transfer passes stage 1,
// where a dot query reads the display memory (single port, registered read data),
// and then loads the output register. The block takes a new request every cycle
// while results drain; stalls come only from rsp.ready.
// Display memory has no reset; the register file and index clear on reset.
`default_nettype none
`include "lcd_controller_index_data_port_defines.svh"
module lcd_controller_index_data_port
	import lcdc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	lcdc_req_if.sink   req,
	lcdc_rsp_if.source rsp
);

	logic [7:0]       rf_q [NUM_REGS];
	logic [IDX_W-1:0] idx_q;

	logic             valid_s1;
	logic             query_s1;
	logic             acc_s1;
	logic             outside_s1;
	logic [1:0]       sel_s1;
	logic             disp_s1;

	logic             out_valid_q;
	logic             out_acc_q;
	logic [1:0]       out_level_q;
	logic             out_disp_q;

	logic             req_fire;
	logic             adv;
	logic             is_idx;
	logic             is_dat;
	logic             dd_wr;
	logic [7:0]       x_cur;
	logic [7:0]       y_cur;
	logic             xy_in;
	logic             dot_in;
	logic             rf_we;
	logic [IDX_W-1:0] rf_waddr;
	logic [7:0]       rf_wdata;
	logic             disp_next;
	logic [MEM_AW-1:0] waddr;
	logic [MEM_AW-1:0] qaddr;
	dmem_req_t        mreq;
	logic [7:0]       rdata;
	logic [1:0]       level_s1;

	always_comb begin
		adv       = !out_valid_q || rsp.ready;
		req.ready = !valid_s1 || adv;
		req_fire  = req.valid && req.ready;

		x_cur  = rf_q[XADDR_REG_NUM];
		y_cur  = rf_q[YADDR_REG_NUM];
		is_idx = !req.op && (req.port_sel == PORT_INDEX);
		is_dat = !req.op && (req.port_sel == PORT_DATA);
		dd_wr  = is_dat && (idx_q == DATA_REG_NUM);
		xy_in  = (32'(x_cur) < STRIDE) && (32'(y_cur) < PANEL_HEIGHT);
		dot_in = (32'(req.dot_x) < PANEL_WIDTH) && (32'(req.dot_y) < PANEL_HEIGHT);

		waddr = MEM_AW'(32'(y_cur) * 32'(STRIDE) + 32'(x_cur));
		qaddr = MEM_AW'(32'(req.dot_y) * 32'(STRIDE) + 32'(req.dot_x[7:2]));

		rf_we    = 1'b0;
		rf_waddr = idx_q;
		rf_wdata = req.write_data;
		if (dd_wr) begin
			rf_we    = 1'b1;
			rf_waddr = XADDR_REG_NUM;
			rf_wdata = mod_stride({1'b0, x_cur} + 9'd1);
		end else if (is_dat) begin
			rf_we = 1'b1;
		end

		disp_next = (rf_we && (rf_waddr == DISP_REG_NUM)) ? rf_wdata[DISP_ON_BIT]
			: rf_q[DISP_REG_NUM][DISP_ON_BIT];

		mreq.we    = req_fire && dd_wr && xy_in;
		mreq.re    = req_fire && req.op && dot_in;
		mreq.addr  = req.op ? qaddr : waddr;
		mreq.wdata = req.write_data;

		level_s1 = outside_s1 ? 2'd3 : 2'(rdata >> {~sel_s1, 1'b0});
	end

	lcdc_dmem u_dmem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				rf_q[i] <= 8'd0;
			end
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				if (is_idx) begin
					idx_q <= req.write_data[IDX_W-1:0];
				end
				if (rf_we) begin
					rf_q[rf_waddr] <= rf_wdata;
				end
			end
			if (req.ready) begin
				valid_s1 <= req_fire;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			query_s1   <= req.op;
			acc_s1     <= is_idx || is_dat;
			outside_s1 <= !dot_in;
			sel_s1     <= req.dot_x[1:0];
			disp_s1    <= disp_next;
		end
		if (adv && valid_s1) begin
			out_acc_q   <= acc_s1;
			out_level_q <= query_s1 ? level_s1 : 2'd0;
			out_disp_q  <= disp_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.accepted   = out_acc_q;
	assign rsp.dot_level  = out_level_q;
	assign rsp.display_on = out_disp_q;

	`LCDC_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1, "stage 1 lost under stall")
	`LCDC_ASSERT_NEXT(a_x_wrap, req_fire && dd_wr, 32'(rf_q[XADDR_REG_NUM]) < STRIDE, "X beyond stride")
	`LCDC_ASSERT_IMPL(a_mem_excl, mreq.we, !mreq.re, "memory read and write together")
	`LCDC_ASSERT_IMPL(a_acc_level, out_valid_q && out_acc_q, out_level_q == 2'd0, "write with level")

endmodule
`default_nettype wire

FILE: design/lcdc_dmem.sv
// Display memory: single-port synchronous RAM, registered read data
`default_nettype none
module lcdc_dmem
	import lcdc_pkg::*;
(
	input  wire logic       clk,
	input  wire dmem_req_t  req,
	output logic [7:0]      rdata
);

	logic [7:0] mem [MEM_SIZE];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: dv/lcdc_tb_pkg.sv
// Testbench package: operation and port codes and the result record
`default_nettype none
package lcdc_tb_pkg;

	localparam logic       OP_WRITE      = 1'b0;
	localparam logic       OP_QUERY      = 1'b1;
	localparam logic [1:0] PORT_OTHER    = 2'd2;
	localparam logic [1:0] PORT_OTHER_HI = 2'd3;

	typedef struct packed {
		logic       accepted;
		logic [1:0] dot_level;
		logic       display_on;
	} lcd_result_t;

endpackage
`default_nettype wire

FILE: dv/lcd_controller_index_data_port_checker.sv
// Checker: predicts each result of the index/data port and compares transfers
`default_nettype none
module lcd_controller_index_data_port_checker
	import lcdc_pkg::*;
	import lcdc_tb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lcdc_req_if       req,
	lcdc_rsp_if       rsp,
	output int        fails,
	output int        results_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] LEVEL_OUTSIDE = 2'd3;

	logic [IDX_W-1:0] cur_index;
	logic [7:0]       regs [NUM_REGS];
	logic [7:0]       vram [MEM_SIZE];
	lcd_result_t      awaited_results [$];
	lcd_result_t      got;
	lcd_result_t      want;

	task automatic report_mismatch(input string what, input int want_v, input int got_v);
		$display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
		fails++;
	endtask

	function automatic lcd_result_t apply_access(input logic op, input logic [1:0] port,
			input logic [7:0] data, input logic [7:0] dx, input logic [7:0] dy);
		lcd_result_t r;
		int          xa;
		int          ya;
		int          xi;
		int          yi;
		logic [7:0]  b;
		r  = '0;
		xi = int'(dx);
		yi = int'(dy);
		if (op == OP_WRITE) begin
			if (port == PORT_INDEX) begin
				cur_index  = data[IDX_W-1:0];
				r.accepted = 1'b1;
			end else if (port == PORT_DATA) begin
				r.accepted = 1'b1;
				if (cur_index == DATA_REG_NUM) begin
					xa = int'(regs[XADDR_REG_NUM]);
					ya = int'(regs[YADDR_REG_NUM]);
					if (xa < STRIDE && ya < PANEL_HEIGHT) begin
						vram[ya * STRIDE + xa] = data;
					end
					regs[XADDR_REG_NUM] = 8'((xa + 1) % STRIDE);
				end else begin
					regs[cur_index] = data;
				end
			end
		end else if (xi >= PANEL_WIDTH || yi >= PANEL_HEIGHT) begin
			r.dot_level = LEVEL_OUTSIDE;
		end else begin
			// leftmost dot in the high bits
			b           = vram[yi * STRIDE + xi / 4];
			r.dot_level = b[6 - 2 * (xi % 4) +: 2];
		end
		r.display_on = regs[DISP_REG_NUM][DISP_ON_BIT];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_index = '0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs[i] = '0;
			end
			awaited_results.delete();
			fails               = 0;
			results_outstanding = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.accepted, rsp.dot_level, rsp.display_on};
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result transfer", 0, 1);
				end else begin
					want = awaited_results.pop_front();
					if (got.accepted !== want.accepted) begin
						report_mismatch("accepted", want.accepted, got.accepted);
					end
					if (got.dot_level !== want.dot_level) begin
						report_mismatch("dot_level", want.dot_level, got.dot_level);
					end
					if (got.display_on !== want.display_on) begin
						report_mismatch("display_on", want.display_on, got.display_on);
					end
				end
			end
			if (req.valid && req.ready) begin
				awaited_results.push_back(apply_access(req.op, req.port_sel, req.write_data,
					req.dot_x, req.dot_y));
			end
			results_outstanding = awaited_results.size();
		end
	end

endmodule
`default_nettype wire

FILE: dv/lcd_controller_index_data_port_tb.sv
// Testbench top: clock, reset, request and result traffic, watchdog and verdict
`default_nettype none
module lcd_controller_index_data_port_tb;
	import lcdc_pkg::*;
	import lcdc_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS       = 1650;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_TICKS = 8;

	logic clk;
	logic arst_n;
	int   fails;
	int   results_outstanding;
	int   idle_ticks;
	int   n_items;
	bit   calm;

	// stimulus-side view of the address registers, so queries only hit written bytes
	logic [IDX_W-1:0] sh_index;
	int               sh_x;
	int               sh_y;
	bit               vram_written [MEM_SIZE];
	int               written_q [$];
	int               last_addr;

	lcdc_req_if req_ch ();
	lcdc_rsp_if rsp_ch ();

	lcd_controller_index_data_port uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	lcd_controller_index_data_port_checker checker_i (
		.clk                 (clk),
		.arst_n              (arst_n),
		.req                 (req_ch),
		.rsp                 (rsp_ch),
		.fails               (fails),
		.results_outstanding (results_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_ticks <= 0;
		end else begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_ticks <= 0;
			end else begin
				idle_ticks <= idle_ticks + 1;
			end
			if (idle_ticks >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// result side: random stall, none while calm, before each transfer
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send(input logic op, input logic [1:0] port, input logic [7:0] data,
			input logic [7:0] dx, input logic [7:0] dy);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.port_sel   <= port;
		req_ch.write_data <= data;
		req_ch.dot_x      <= dx;
		req_ch.dot_y      <= dy;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		n_items++;
		@(negedge clk);
	endtask

	task automatic wr(input logic [1:0] port, input logic [7:0] data);
		int a;
		if (port == PORT_INDEX) begin
			sh_index = data[IDX_W-1:0];
		end else if (port == PORT_DATA) begin
			if (sh_index == DATA_REG_NUM) begin
				if (sh_x < STRIDE && sh_y < PANEL_HEIGHT) begin
					a = sh_y * STRIDE + sh_x;
					if (!vram_written[a]) begin
						vram_written[a] = 1'b1;
						written_q.push_back(a);
					end
					last_addr = a;
				end
				sh_x = (sh_x + 1) % STRIDE;
			end else begin
				if (sh_index == XADDR_REG_NUM) sh_x = int'(data);
				if (sh_index == YADDR_REG_NUM) sh_y = int'(data);
			end
		end
		send(OP_WRITE, port, data, 8'($urandom), 8'($urandom));
	endtask

	task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
		wr(PORT_INDEX, {3'($urandom_range(0, 7)), idx});
		wr(PORT_DATA, val);
	endtask

	task automatic ask(input int dx, input int dy);
		send(OP_QUERY, 2'($urandom), 8'($urandom), 8'(dx), 8'(dy));
	endtask

	task automatic ask_outside();
		if ($urandom_range(0, 1)) begin
			ask($urandom_range(PANEL_WIDTH, 255), $urandom_range(0, 255));
		end else begin
			ask($urandom_range(0, 255), $urandom_range(PANEL_HEIGHT, 255));
		end
	endtask

	task automatic ask_written(input bit recent);
		int a;
		if (written_q.size() == 0) begin
			ask_outside();
		end else begin
			a = (recent && last_addr >= 0) ? last_addr
				: written_q[$urandom_range(0, written_q.size() - 1)];
			ask((a % STRIDE) * 4 + $urandom_range(0, 3), a / STRIDE);
		end
	endtask

	initial begin
		int len;
		req_ch.valid      = 1'b0;
		req_ch.op         = OP_WRITE;
		req_ch.port_sel   = PORT_INDEX;
		req_ch.write_data = '0;
		req_ch.dot_x      = '0;
		req_ch.dot_y      = '0;
		arst_n            = 1'b0;
		n_items           = 0;
		calm              = 1'b0;
		sh_index          = '0;
		sh_x              = 0;
		sh_y              = 0;
		last_addr         = -1;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed
		ask(255, 255);
		ask(PANEL_WIDTH, 0);
		ask(0, PANEL_HEIGHT);
		wr(PORT_OTHER, 8'hFF);
		wr(PORT_OTHER_HI, 8'h00);
		wr(PORT_INDEX, {3'b111, DISP_REG_NUM});
		wr(PORT_DATA, 8'h40);
		wr(PORT_INDEX, 8'hFF);
		wr(PORT_DATA, 8'hAA);
		set_reg(XADDR_REG_NUM, 8'(STRIDE - 1));
		set_reg(YADDR_REG_NUM, 8'(PANEL_HEIGHT - 1));
		wr(PORT_INDEX, {3'b000, DATA_REG_NUM});
		wr(PORT_DATA, 8'hE4);
		wr(PORT_DATA, 8'h1B);
		ask(0, PANEL_HEIGHT - 1);
		for (int k = 0; k < 4; k++) begin
			ask((STRIDE - 1) * 4 + k, PANEL_HEIGHT - 1);
		end
		set_reg(XADDR_REG_NUM, 8'd200);
		wr(PORT_INDEX, {3'b010, DATA_REG_NUM});
		wr(PORT_DATA, 8'h55);
		set_reg(DISP_REG_NUM, 8'hBF);

		// random
		while (n_items < ITEMS) begin
			if ($urandom_range(0, 7) == 0) calm = ~calm;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					set_reg(XADDR_REG_NUM, ($urandom_range(0, 7) == 0) ? 8'($urandom)
						: 8'($urandom_range(0, STRIDE - 1)));
					set_reg(YADDR_REG_NUM, ($urandom_range(0, 9) == 0) ? 8'($urandom)
						: 8'($urandom_range(0, PANEL_HEIGHT - 1)));
					wr(PORT_INDEX, {3'($urandom_range(0, 7)), DATA_REG_NUM});
					len = $urandom_range(1, 48);
					for (int k = 0; k < len; k++) begin
						wr(PORT_DATA, 8'($urandom));
						if ($urandom_range(0, 2) == 0) ask_written($urandom_range(0, 1));
					end
				end
				4, 5: begin
					len = $urandom_range(1, 8);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 3) == 0) ask_outside();
						else ask_written($urandom_range(0, 3) == 0);
					end
				end
				6: set_reg(5'($urandom), 8'($urandom));
				7: set_reg(DISP_REG_NUM, 8'($urandom));
				8: begin
					len = $urandom_range(1, 3);
					for (int k = 0; k < len; k++) begin
						wr($urandom_range(0, 1) ? PORT_OTHER : PORT_OTHER_HI, 8'($urandom));
					end
					wr(PORT_INDEX, 8'($urandom));
				end
				default: begin
					if ($urandom_range(0, 1)) begin
						set_reg(XADDR_REG_NUM, 8'($urandom_range(STRIDE, 255)));
					end else begin
						set_reg(YADDR_REG_NUM, 8'($urandom_range(PANEL_HEIGHT, 255)));
					end
					wr(PORT_INDEX, {3'($urandom_range(0, 7)), DATA_REG_NUM});
					len = $urandom_range(1, 4);
					for (int k = 0; k < len; k++) begin
						wr(PORT_DATA, 8'($urandom));
					end
				end
			endcase
		end
		req_ch.valid <= 1'b0;

		while (results_outstanding != 0) @(negedge clk);
		repeat (DRAIN_TICKS) @(negedge clk);
		if (fails == 0 && results_outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+design
design/lcdc_pkg.sv
design/lcdc_if.sv
design/lcdc_dmem.sv
design/lcd_controller_index_data_port.sv
dv/lcdc_tb_pkg.sv
dv/lcd_controller_index_data_port_checker.sv
dv/lcd_controller_index_data_port_tb.sv
